// ===== rtl/core/wet_pkg.sv =====
package wet_pkg;

  localparam int unsigned WAVE_INDEX_BITS = 11;
  localparam int unsigned PHASE_FRAC_BITS = 12;
  localparam int unsigned WAVE_SEL_BITS   = 3;
  localparam int unsigned STORE_ADDR_W    = WAVE_SEL_BITS + WAVE_INDEX_BITS;
  localparam int unsigned STORE_DEPTH     = 1 << STORE_ADDR_W;

  localparam int unsigned HOST_CLK_W    = 24;
  localparam int unsigned OUT_RATE_W    = 18;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 24;
  localparam int unsigned PHASE_W       = 32;
  localparam int unsigned MULT_W        = 13;
  localparam int unsigned CLK_DIV_SHIFT = 6;
  localparam int unsigned PROD_W        = HOST_CLK_W - CLK_DIV_SHIFT + MULT_W;
  localparam int unsigned CLK_SHIFT     = 10;
  localparam int unsigned SAMPLE_W      = 7;

  localparam logic [HOST_CLK_W-1:0] HOST_CLK_RESET = HOST_CLK_W'(3072000);
  localparam logic [OUT_RATE_W-1:0] OUT_RATE_RESET = OUT_RATE_W'(44100);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOW   = 2'd1,
    ACT_HIGH  = 2'd2,
    ACT_LOAD  = 2'd3
  } action_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_HOST_CLK    = 2'd0,
    CFG_OUTPUT_RATE = 2'd1
  } cfg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  function automatic logic [7:0] wave_volume(input logic [WAVE_SEL_BITS-1:0] wave);
    logic [7:0] vol;
    case (wave)
      3'd0:    vol = 8'd27;
      3'd1:    vol = 8'd40;
      3'd2:    vol = 8'd55;
      3'd3:    vol = 8'd68;
      3'd4:    vol = 8'd87;
      3'd5:    vol = 8'd100;
      3'd6:    vol = 8'd115;
      default: vol = 8'd128;
    endcase
    return vol;
  endfunction

endpackage

// ===== rtl/core/wavetable_engine_tone_unit.sv =====
// Control writes and table loads are taken in idle; the next item is taken in the next cycle.
// A tick with the tone enabled passes through ST_MUL (multiply), ST_DIV (the bit-serial
// phase-step divider; the phase is updated as it finishes) and ST_DONE, which outputs the
// result once the output register is free; no new item is taken until the unit is idle again.
// A silent tick (disabled or zero output rate) goes straight to ST_DONE with a zero result.
// Reset clears phase, rate and enable, and sets the host clock and output rates to defaults;
// the wave store is not cleared and must be loaded before it is played.
module wavetable_engine_tone_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [wet_pkg::STORE_ADDR_W-1:0]   table_address_i,
  input  logic [7:0]                         data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wet_pkg::SAMPLE_W-1:0]       sample_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wet_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [wet_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import wet_pkg::*;

  state_e                    state_q, state_d;
  logic [HOST_CLK_W-1:0]     host_clk_q;
  logic [OUT_RATE_W-1:0]     out_rate_q;
  logic [PHASE_W-1:0]        phase_q, phase_d;
  logic [5:0]                rate_high_q, rate_high_d;
  logic [5:0]                rate_low_q, rate_low_d;
  logic                      enable_q, enable_d;
  logic                      out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]       sample_q, sample_d;
  logic [SAMPLE_W-1:0]       res_q, res_d;

  logic                      in_xfer;
  logic                      out_free;
  logic [MULT_W-1:0]         mult;
  logic [PROD_W-1:0]         prod;
  logic [PHASE_W-1:0]        dividend;
  logic                      div_start;
  logic                      div_done;
  logic [PHASE_W-1:0]        quotient;
  logic                      ram_we;
  logic [STORE_ADDR_W-1:0]   ram_raddr;
  logic [7:0]                ram_rdata;
  logic [WAVE_SEL_BITS-1:0]  wave;
  logic [15:0]               scaled;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      host_clk_q <= HOST_CLK_RESET;
      out_rate_q <= OUT_RATE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_HOST_CLK:    host_clk_q <= cfg_data_i[HOST_CLK_W-1:0];
        CFG_OUTPUT_RATE: out_rate_q <= cfg_data_i[OUT_RATE_W-1:0];
        default:         ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign wave      = rate_high_q[5:5-WAVE_SEL_BITS+1];
  assign ram_we    = in_xfer && (action_e'(action_i) == ACT_LOAD);
  assign ram_raddr = {wave, phase_q[PHASE_FRAC_BITS +: WAVE_INDEX_BITS]};

  wet_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (table_address_i),
    .wdata_i (data_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign mult      = MULT_W'({{1'b0, rate_high_q} + 7'd1, 6'd0}) + MULT_W'(rate_low_q) +
                     MULT_W'(1);
  assign prod      = PROD_W'(host_clk_q[HOST_CLK_W-1:CLK_DIV_SHIFT]) * PROD_W'(mult);
  assign dividend  = PHASE_W'(prod >> CLK_SHIFT) << PHASE_FRAC_BITS;
  assign div_start = (state_q == ST_MUL);

  wet_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (out_rate_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign scaled = 16'(ram_rdata) * 16'(wave_volume(wave));

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    rate_high_d = rate_high_q;
    rate_low_d  = rate_low_q;
    enable_d    = enable_q;
    res_d       = res_q;
    sample_d    = sample_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (action_e'(action_i))
            ACT_TICK: begin
              if (!enable_q || out_rate_q == '0) begin
                res_d   = '0;
                state_d = ST_DONE;
              end else begin
                state_d = ST_MUL;
              end
            end
            ACT_LOW: begin
              rate_low_d = {data_i[5:1], 1'b0};
              enable_d   = data_i[0];
            end
            ACT_HIGH: rate_high_d = data_i[5:0];
            default:  ;
          endcase
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          res_d   = scaled[8 +: SAMPLE_W];
          phase_d = phase_q + quotient;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_d = 1'b1;
          sample_d    = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      rate_high_q <= '0;
      rate_low_q  <= '0;
      enable_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rate_high_q <= rate_high_d;
      rate_low_q  <= rate_low_d;
      enable_q    <= enable_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    sample_q <= sample_d;
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;

endmodule

// ===== rtl/core/wet_ram.sv =====
module wet_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/wet_div.sv =====
module wet_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [wet_pkg::PHASE_W-1:0]     dividend_i,
  input  logic [wet_pkg::OUT_RATE_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic [wet_pkg::PHASE_W-1:0]     quotient_o
);
  import wet_pkg::*;

  localparam int unsigned CNT_W = $clog2(PHASE_W);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [PHASE_W-1:0]    dvd_q, dvd_d;
  logic [OUT_RATE_W-1:0] rem_q, rem_d;
  logic [OUT_RATE_W-1:0] dsr_q, dsr_d;
  logic [OUT_RATE_W:0]   rem_sh;
  logic                  ge;

  // One quotient bit per cycle, restoring; quotient bits shift into the dividend register.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, dvd_q[PHASE_W-1]};
    ge     = (rem_sh >= {1'b0, dsr_q});
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? OUT_RATE_W'(rem_sh - {1'b0, dsr_q}) : OUT_RATE_W'(rem_sh);
      dvd_d = {dvd_q[PHASE_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(PHASE_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

// ===== tb/sv/tb_wavetable_engine_tone_unit.sv =====
`timescale 1ns / 1ps

module tb_wavetable_engine_tone_unit;
  import wet_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  // indexes past the end of the register list; writes to them are dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [7:0] VOLUME_BY_WAVE [8] = '{8'd27, 8'd40, 8'd55, 8'd68,
                                                8'd87, 8'd100, 8'd115, 8'd128};

  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    in_valid_i      = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              action_i        = ACT_TICK;
  logic [STORE_ADDR_W-1:0] table_address_i = '0;
  logic [7:0]              data_i          = '0;
  logic                    out_valid_o;
  logic                    out_stall_i     = 1'b0;
  logic [SAMPLE_W-1:0]     sample_o;
  logic                    cfg_valid_i     = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_INDEX_W-1:0]  cfg_index_i     = CFG_HOST_CLK;
  logic [CFG_DATA_W-1:0]   cfg_data_i      = '0;

  wavetable_engine_tone_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .table_address_i (table_address_i),
    .data_i          (data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_o        (sample_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // tone generator mirror
  logic [HOST_CLK_W-1:0]  tone_host_clk  = HOST_CLK_RESET;
  logic [OUT_RATE_W-1:0]  tone_out_rate  = OUT_RATE_RESET;
  logic [PHASE_W-1:0]     tone_phase     = '0;
  logic [5:0]             tone_rate_high = '0;
  logic [5:0]             tone_rate_low  = '0;
  logic                   tone_enable    = 1'b0;
  logic [7:0]             tone_store [STORE_DEPTH];
  bit                     tone_written [STORE_DEPTH];

  logic [SAMPLE_W-1:0] pending_samples [$];
  logic [SAMPLE_W-1:0] want_sample;

  int unsigned send_gap_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned sample_count   = 0;
  int unsigned quiet_cycles   = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ERROR: %s", $time, msg);
    mismatch_count++;
  endtask

  // apply one accepted item to the mirror and queue the sample it yields
  task automatic advance_tone(input action_e act, input logic [STORE_ADDR_W-1:0] addr,
                              input logic [7:0] dat);
    logic [31:0] mult;
    logic [31:0] tone_clock;
    logic [31:0] step;
    logic [2:0]  wave;
    logic [15:0] prod;
    case (act)
      ACT_LOW: begin
        tone_rate_low = {dat[5:1], 1'b0};
        tone_enable   = dat[0];
      end
      ACT_HIGH: tone_rate_high = dat[5:0];
      ACT_LOAD: begin
        tone_store[addr]   = dat;
        tone_written[addr] = 1'b1;
      end
      default: begin
        if (!tone_enable || tone_out_rate == '0) begin
          pending_samples.push_back('0);
        end else begin
          mult       = (32'(tone_rate_high) + 32'd1) * 32'd64 + 32'(tone_rate_low) + 32'd1;
          tone_clock = ((32'(tone_host_clk) / 32'd64) * mult) / 32'd1024;
          step       = (tone_clock << PHASE_FRAC_BITS) / 32'(tone_out_rate);
          wave       = tone_rate_high[5:3];
          prod       = 16'(tone_store[{wave, tone_phase[PHASE_FRAC_BITS +: WAVE_INDEX_BITS]}])
                       * 16'(VOLUME_BY_WAVE[wave]);
          pending_samples.push_back(prod[14:8]);
          tone_phase = tone_phase + step;
        end
      end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_item(input action_e act, input logic [STORE_ADDR_W-1:0] addr,
                           input logic [7:0] dat);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    action_i        = act;
    table_address_i = addr;
    data_i          = dat;
    do @(posedge clk_i); while (in_stall_o);
    advance_tone(act, addr, dat);
    @(negedge clk_i);
  endtask

  task automatic send_tick();
    logic [STORE_ADDR_W-1:0] rd_addr;
    rd_addr = {tone_rate_high[5:3], tone_phase[PHASE_FRAC_BITS +: WAVE_INDEX_BITS]};
    // load the byte this tick plays if it was never written
    if (tone_enable && tone_out_rate != '0 && !tone_written[rd_addr]) begin
      send_item(ACT_LOAD, rd_addr, 8'($urandom));
    end
    send_item(ACT_TICK, STORE_ADDR_W'($urandom), 8'($urandom));
  endtask

  // wait for every queued sample, then let the engine settle
  task automatic drain_samples();
    in_valid_i = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_samples();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_HOST_CLK) begin
      tone_host_clk = val[HOST_CLK_W-1:0];
    end else if (idx == CFG_OUTPUT_RATE) begin
      tone_out_rate = val[OUT_RATE_W-1:0];
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic test_control_writes();
    send_tick();
    send_item(ACT_LOAD, '0, 8'hFF);
    send_item(ACT_LOAD, '1, 8'h00);
    send_item(ACT_HIGH, STORE_ADDR_W'($urandom), 8'h00);
    send_item(ACT_LOW, STORE_ADDR_W'($urandom), 8'h01);
    send_tick();
    // fraction set but tone off: silent, phase holds
    send_item(ACT_LOW, STORE_ADDR_W'($urandom), 8'hFE);
    send_tick();
    send_item(ACT_LOW, STORE_ADDR_W'($urandom), 8'hFF);
    send_item(ACT_HIGH, STORE_ADDR_W'($urandom), 8'hFF);
    send_tick();
    send_tick();
    send_item(ACT_HIGH, STORE_ADDR_W'($urandom), 8'hC0);
    send_tick();
    for (int w = 0; w < 8; w++) begin
      send_item(ACT_HIGH, STORE_ADDR_W'($urandom),
                {2'($urandom), 3'(w), 3'($urandom)});
      send_tick();
    end
  endtask

  task automatic test_register_extremes();
    send_item(ACT_LOW, STORE_ADDR_W'($urandom), 8'h0B);
    send_item(ACT_HIGH, STORE_ADDR_W'($urandom), 8'h2A);
    // zero clock: step is zero, same byte every tick
    write_reg(CFG_HOST_CLK, '0);
    repeat (3) send_tick();
    write_reg(CFG_HOST_CLK, '1);
    write_reg(CFG_OUTPUT_RATE, 24'd1);
    repeat (3) send_tick();
    write_reg(CFG_OUTPUT_RATE, '0);
    repeat (2) send_tick();
    // upper data bits fall outside the rate register
    write_reg(CFG_OUTPUT_RATE, '1);
    repeat (2) send_tick();
    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, '1);
    repeat (2) send_tick();
    write_reg(CFG_HOST_CLK, 24'd1);
    repeat (2) send_tick();
    write_reg(CFG_HOST_CLK, CFG_DATA_W'(HOST_CLK_RESET));
    write_reg(CFG_OUTPUT_RATE, CFG_DATA_W'(OUT_RATE_RESET));
    repeat (2) send_tick();
  endtask

  task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned stall_pct,
                                     input int unsigned n_items);
    int unsigned pick;
    logic [7:0]  dat;
    pick = $urandom_range(3);
    case (pick)
      0:       write_reg(CFG_HOST_CLK, CFG_DATA_W'($urandom));
      1:       write_reg(CFG_HOST_CLK, CFG_DATA_W'($urandom_range(16777215, 16000000)));
      default: write_reg(CFG_HOST_CLK, CFG_DATA_W'($urandom_range(8000000, 1000000)));
    endcase
    pick = $urandom_range(3);
    case (pick)
      0:       write_reg(CFG_OUTPUT_RATE, CFG_DATA_W'($urandom));
      1:       write_reg(CFG_OUTPUT_RATE, CFG_DATA_W'($urandom_range(255, 1)));
      default: write_reg(CFG_OUTPUT_RATE, CFG_DATA_W'($urandom_range(96000, 8000)));
    endcase
    send_gap_pct   = gap_pct;
    sink_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      dat  = 8'($urandom);
      if (pick < 58) begin
        send_tick();
      end else if (pick < 68) begin
        // keep the tone on most of the time
        dat[0] = ($urandom_range(9) < 8);
        send_item(ACT_LOW, STORE_ADDR_W'($urandom), dat);
      end else if (pick < 78) begin
        send_item(ACT_HIGH, STORE_ADDR_W'($urandom), dat);
      end else begin
        send_item(ACT_LOAD, STORE_ADDR_W'($urandom), dat);
      end
    end
    drain_samples();
    send_gap_pct   = 0;
    sink_stall_pct = 0;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sample_count++;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d = %0d with none pending",
                                  sample_count, sample_o));
      end else begin
        want_sample = pending_samples.pop_front();
        if (sample_o !== want_sample) begin
          report_mismatch($sformatf("sample %0d: got %0d, expected %0d",
                                    sample_count, sample_o, want_sample));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_wavetable_engine_tone_unit NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_control_writes();
    test_register_extremes();
    test_random_traffic(0, 0, 90);
    test_random_traffic(63, 0, 90);
    test_random_traffic(0, 63, 90);
    test_random_traffic(8, 8, 90);
    drain_samples();
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("tb_wavetable_engine_tone_unit OK");
    end else begin
      $display("tb_wavetable_engine_tone_unit NOT OK");
    end
    $finish;
  end

endmodule
